### rtl/core/b3blur_pkg.sv
// ----------------------------------------------------------------------------
// b3blur_pkg
// Shared constants, codes and types of the 3x3 binomial blur with clamped edges.
// ----------------------------------------------------------------------------
package b3blur_pkg;

    // default parameter values
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration register widths and limits
    localparam int LW_BITS     = 11;
    localparam int FH_BITS     = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int ROW_BITS    = 12;
    localparam int IN_ROW_BITS = 13;

    localparam logic [LW_BITS-1:0] LW_RESET = LW_BITS'(1024);
    localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(1024);

    // apb port geometry
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register indexes
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // input opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // per push control travelling from the counters to the datapath
    typedef struct packed {
        logic due;
        logic edge_l;
        logic edge_r;
        logic edge_u;
        logic edge_d;
        logic last;
    } ctl_t;

endpackage

### rtl/core/b3blur_if.sv
// ----------------------------------------------------------------------------
// b3blur_if
// Stream channels of the blur: pixel beats in, blurred beats out.
// ----------------------------------------------------------------------------
interface b3blur_in_if #(
    parameter int SAMPLE_BITS = b3blur_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface b3blur_out_if #(
    parameter int SAMPLE_BITS = b3blur_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS+3:0]   blurred;
    logic                            frame_last;

    modport source (output valid, output blurred, output frame_last, input ready);
    modport sink   (input valid, input blurred, input frame_last, output ready);
endinterface

### rtl/core/b3blur_ram.sv
// ----------------------------------------------------------------------------
// b3blur_ram
// Generic simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module b3blur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/b3blur_ctrl.sv
// ----------------------------------------------------------------------------
// b3blur_ctrl
// Configuration registers and raster position counters of the blur.
// ----------------------------------------------------------------------------
module b3blur_ctrl #(
    parameter int MAX_WIDTH = b3blur_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [b3blur_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [b3blur_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [b3blur_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                   pready,
    input  logic                                   accept,
    input  logic                                   opcode,
    output logic                                   push,
    output logic [$clog2(MAX_WIDTH)-1:0]           addr,
    output b3blur_pkg::ctl_t                       ctl
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int EW_BITS  = (COL_BITS + 1 > b3blur_pkg::LW_BITS) ?
                              COL_BITS + 1 : b3blur_pkg::LW_BITS;
    localparam int RB       = b3blur_pkg::ROW_BITS;
    localparam int IRB      = b3blur_pkg::IN_ROW_BITS;

    logic [b3blur_pkg::LW_BITS-1:0] lw_reg, lw_next;
    logic [b3blur_pkg::FH_BITS-1:0] fh_reg, fh_next;
    logic [COL_BITS-1:0]            in_col_reg, in_col_next;
    logic [IRB-1:0]                 in_row_reg, in_row_next;
    logic [COL_BITS-1:0]            out_col_reg, out_col_next;
    logic [RB-1:0]                  out_row_reg, out_row_next;
    logic                           in_done_reg, in_done_next;

    logic                cfg_wr;
    logic                cfg_idx;
    logic [COL_BITS-1:0] last_col;
    logic [RB-1:0]       last_row;
    logic                at_last_in;
    logic                due;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[b3blur_pkg::APB_ADDR_BITS-1];

    // register read back
    always_comb
    begin
        case (cfg_idx)
            b3blur_pkg::REG_LINE_WIDTH:   prdata = b3blur_pkg::APB_DATA_BITS'(lw_reg);
            b3blur_pkg::REG_FRAME_HEIGHT: prdata = b3blur_pkg::APB_DATA_BITS'(fh_reg);
            default:                      prdata = '0;
        endcase
    end

    // effective last column and row, zero acts as one, large values saturate
    always_comb
    begin
        if (lw_reg == '0)
        begin
            last_col = '0;
        end
        else if (EW_BITS'(lw_reg) > EW_BITS'(MAX_WIDTH))
        begin
            last_col = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_BITS'(lw_reg - 1'b1);
        end

        if (fh_reg == '0)
        begin
            last_row = '0;
        end
        else if (fh_reg > b3blur_pkg::FH_BITS'(b3blur_pkg::MAX_HEIGHT))
        begin
            last_row = RB'(b3blur_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = RB'(fh_reg - 1'b1);
        end
    end

    assign at_last_in = (in_row_reg == IRB'(last_row)) && (in_col_reg == last_col);
    assign due        = (in_row_reg >= IRB'(2)) ||
                        ((in_row_reg == IRB'(1)) && (in_col_reg != '0));
    assign addr       = in_col_reg;

    // push decision and border flags for the result this push completes
    always_comb
    begin
        push = 1'b0;
        if (accept)
        begin
            if (opcode == b3blur_pkg::OP_PIXEL)
            begin
                push = !in_done_reg;
            end
            else
            begin
                push = in_done_reg;
            end
        end
        ctl.due    = due;
        ctl.edge_l = (out_col_reg == '0);
        ctl.edge_r = (out_col_reg == last_col);
        ctl.edge_u = (out_row_reg == '0);
        ctl.edge_d = (out_row_reg == last_row);
        ctl.last   = (out_row_reg == last_row) && (out_col_reg == last_col);
    end

    // counter update
    always_comb
    begin
        lw_next      = lw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        in_done_next = in_done_reg;

        if (cfg_wr)
        begin
            case (cfg_idx)
                b3blur_pkg::REG_LINE_WIDTH:   lw_next = pwdata[b3blur_pkg::LW_BITS-1:0];
                b3blur_pkg::REG_FRAME_HEIGHT: fh_next = pwdata[b3blur_pkg::FH_BITS-1:0];
                default:                      lw_next = lw_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            in_done_next = 1'b0;
        end
        else if (push)
        begin
            if (opcode == b3blur_pkg::OP_PIXEL && at_last_in)
            begin
                in_done_next = 1'b1;
            end

            if (in_col_reg == last_col)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end

            if (due)
            begin
                if (ctl.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    in_done_next = 1'b0;
                end
                else if (out_col_reg == last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg      <= b3blur_pkg::LW_RESET;
            fh_reg      <= b3blur_pkg::FH_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            in_done_reg <= 1'b0;
        end
        else
        begin
            lw_reg      <= lw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            in_done_reg <= in_done_next;
        end
    end

`ifndef ASSERT_OFF
    // the last pixel always moves the input position past row zero
    a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> (in_row_reg != '0))
        else $error("input done while input row is zero");

    // output position never overtakes input position
    a_out_behind: assert property (@(posedge clk) disable iff (!rst_n)
        IRB'(out_row_reg) <= in_row_reg)
        else $error("output row ahead of input row");
`endif

endmodule

### rtl/core/b3blur_dp.sv
// ----------------------------------------------------------------------------
// b3blur_dp
// Line buffer ram, 3x3 window and weighted sum pipeline of the blur.
// ----------------------------------------------------------------------------
module b3blur_dp #(
    parameter int MAX_WIDTH   = b3blur_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = b3blur_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [$clog2(MAX_WIDTH)-1:0]    addr,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  b3blur_pkg::ctl_t                ctl,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS+3:0]   blurred,
    output logic                            frame_last
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int SB       = SAMPLE_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam int OUT_BITS = SAMPLE_BITS + 4;

    // stage 1: ram data arrives
    logic                 s1_valid_reg, s1_valid_next;
    b3blur_pkg::ctl_t     s1_ctl_reg;
    logic [COL_BITS-1:0]  s1_addr_reg;
    logic signed [SB-1:0] s1_sample_reg;
    logic                 fwd_reg, fwd_next;
    logic signed [SB-1:0] fwd_a_reg;
    logic signed [SB-1:0] fwd_b_reg;

    // window, column 0 newest, tap 0 current row
    logic signed [SB-1:0] win_reg [3][3];
    logic signed [SB-1:0] wn [3][3];

    // stage 2: partial sums
    logic                       s2_valid_reg, s2_valid_next;
    logic signed [SB-1:0]       s2_cen_reg;
    logic signed [SUM_BITS-1:0] s2_esum_reg;
    logic signed [SUM_BITS-1:0] s2_ksum_reg;
    logic                       s2_last_reg;

    logic                       out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0] out_sum_reg;
    logic                       out_last_reg;

    logic [2*SB-1:0]      rdata;
    logic [2*SB-1:0]      wdata;
    logic                 we;
    logic signed [SB-1:0] t1;
    logic signed [SB-1:0] t2;
    logic signed [SB-1:0] c_u, c_d, l_c, l_u, l_d, r_c, r_u, r_d;
    logic signed [SUM_BITS-1:0] esum;
    logic signed [SUM_BITS-1:0] ksum;
    logic signed [OUT_BITS-1:0] total;

    assign advance = !(out_valid_reg && !out_ready && s2_valid_reg);

    // line buffers: low half one row back, high half two rows back
    b3blur_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (we),
        .waddr (s1_addr_reg),
        .wdata (wdata),
        .re    (push),
        .raddr (addr),
        .rdata (rdata)
    );

    // forwarding of a write that hit the address read in the same cycle
    assign t1    = fwd_reg ? fwd_a_reg : rdata[SB-1:0];
    assign t2    = fwd_reg ? fwd_b_reg : rdata[2*SB-1:SB];
    assign we    = advance && s1_valid_reg;
    assign wdata = {t1, s1_sample_reg};

    assign s1_valid_next = push;
    assign fwd_next      = push && s1_valid_reg && (addr == s1_addr_reg);

    // next window after this push
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k == 0)
            begin
                wn[0][0] = s1_sample_reg;
                wn[0][1] = t1;
                wn[0][2] = t2;
            end
            else
            begin
                wn[k] = win_reg[k-1];
            end
        end
    end

    // border clamped neighbour selection
    always_comb
    begin
        c_u  = s1_ctl_reg.edge_u ? wn[1][1] : wn[1][2];
        c_d  = s1_ctl_reg.edge_d ? wn[1][1] : wn[1][0];
        l_c  = s1_ctl_reg.edge_l ? wn[1][1] : wn[2][1];
        l_u  = s1_ctl_reg.edge_l ? c_u : (s1_ctl_reg.edge_u ? wn[2][1] : wn[2][2]);
        l_d  = s1_ctl_reg.edge_l ? c_d : (s1_ctl_reg.edge_d ? wn[2][1] : wn[2][0]);
        r_c  = s1_ctl_reg.edge_r ? wn[1][1] : wn[0][1];
        r_u  = s1_ctl_reg.edge_r ? c_u : (s1_ctl_reg.edge_u ? wn[0][1] : wn[0][2]);
        r_d  = s1_ctl_reg.edge_r ? c_d : (s1_ctl_reg.edge_d ? wn[0][1] : wn[0][0]);
        esum = SUM_BITS'(l_c) + SUM_BITS'(r_c) + SUM_BITS'(c_u) + SUM_BITS'(c_d);
        ksum = SUM_BITS'(l_u) + SUM_BITS'(l_d) + SUM_BITS'(r_u) + SUM_BITS'(r_d);
    end

    assign s2_valid_next = s1_valid_reg && s1_ctl_reg.due;

    // final weighted sum: corners at unit weight, edges at double, centre at double that
    assign total = (OUT_BITS'(s2_cen_reg) <<< 2) + (OUT_BITS'(s2_esum_reg) <<< 1)
                 + OUT_BITS'(s2_ksum_reg);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && s2_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= s1_valid_next;
                fwd_reg      <= fwd_next;
                s2_valid_reg <= s2_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (push)
            begin
                s1_ctl_reg    <= ctl;
                s1_addr_reg   <= addr;
                s1_sample_reg <= sample;
            end
            fwd_a_reg <= s1_sample_reg;
            fwd_b_reg <= t1;
            if (s1_valid_reg)
            begin
                win_reg <= wn;
            end
            if (s2_valid_next)
            begin
                s2_cen_reg  <= wn[1][1];
                s2_esum_reg <= esum;
                s2_ksum_reg <= ksum;
                s2_last_reg <= s1_ctl_reg.last;
            end
            if (s2_valid_reg)
            begin
                out_sum_reg  <= total;
                out_last_reg <= s2_last_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign blurred    = out_sum_reg;
    assign frame_last = out_last_reg;

`ifndef ASSERT_OFF
    // forwarding only ever refers to an item in stage 1
    a_fwd_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag without stage 1 item");

    // a new result beat comes only from a filled stage 2
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result beat without stage 2 item");

    // a blocked output freezes the pipeline
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s2_valid_reg)
            |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved while output blocked");
`endif

endmodule

### rtl/core/blur3x3_binomial_clamped_edge.sv
// Pipeline: the beat completing a window, line_width + 1 pushes after the centre pixel,
//   enters stage 1 when accepted; its result then passes stage 2 and the output register.
// Throughput: a beat per cycle unless stalled, set by the single ram read and write port.
// Reset: counters cleared, line_width and frame_height at 1024, pipeline empty;
//   line buffer contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// blur3x3_binomial_clamped_edge
// Streaming 3x3 binomial blur with replicated borders over one image slice.
// ----------------------------------------------------------------------------
module blur3x3_binomial_clamped_edge #(
    parameter int MAX_WIDTH   = b3blur_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = b3blur_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [b3blur_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [b3blur_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [b3blur_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                 pready,
    b3blur_in_if.sink                            pix_in,
    b3blur_out_if.source                         pix_out
);

    logic                           advance;
    logic                           accept;
    logic                           push;
    logic [$clog2(MAX_WIDTH)-1:0]   addr;
    b3blur_pkg::ctl_t               ctl;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic signed [SAMPLE_BITS+3:0]  blurred;
    logic                           frame_last;
    logic                           out_valid;

    // input beat handshake
    assign pix_in.ready = advance;
    assign accept       = pix_in.valid && advance;
    assign sample       = SAMPLE_BITS'(pix_in.sample);

    // configuration and raster counters
    b3blur_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .accept  (accept),
        .opcode  (pix_in.opcode),
        .push    (push),
        .addr    (addr),
        .ctl     (ctl)
    );

    // line buffers, window and sum
    b3blur_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .addr       (addr),
        .sample     (sample),
        .ctl        (ctl),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (pix_out.ready),
        .blurred    (blurred),
        .frame_last (frame_last)
    );

    // output beat
    assign pix_out.valid      = out_valid;
    assign pix_out.blurred    = blurred;
    assign pix_out.frame_last = frame_last;

endmodule

### verif/blur3x3_binomial_clamped_edge_tb.sv
// ----------------------------------------------------------------------------
// blur3x3_binomial_clamped_edge_tb
// Self-checking bench for the 3x3 binomial blur with replicated borders.
// Streams whole and partial slices under many geometries with random gaps on
// both sides, predicts every blurred beat and compares it field by field.
// ----------------------------------------------------------------------------
module blur3x3_binomial_clamped_edge_tb;

    localparam int SB            = b3blur_pkg::SAMPLE_BITS_DEF;
    localparam int OB            = b3blur_pkg::SAMPLE_BITS_DEF + 4;
    localparam int LINE_MAX      = b3blur_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE        = 8;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_PUSHES = 600;

    typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_t;

    typedef struct packed {
        logic [OB-1:0] blurred;
        logic          frame_last;
    } blur_beat_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [b3blur_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [b3blur_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [b3blur_pkg::APB_DATA_BITS-1:0] prdata;
    logic                                 pready;

    b3blur_in_if  #(.SAMPLE_BITS(SB)) pix_in ();
    b3blur_out_if #(.SAMPLE_BITS(SB)) pix_out ();

    blur3x3_binomial_clamped_edge dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    // blurred beats still owed, oldest first
    blur_beat_t  owed_beats[$];
    int          mismatches   = 0;
    int unsigned pushed_beats = 0;
    int unsigned cycle_count  = 0;
    int          in_gap_max   = 11;
    int          out_gap_max  = 11;

    // predicted block state
    logic signed [SB-1:0]           row_above  [LINE_MAX];
    logic signed [SB-1:0]           row_above2 [LINE_MAX];
    logic signed [SB-1:0]           win [3][3];
    int unsigned                    push_col;
    int unsigned                    push_row;
    int unsigned                    emit_col;
    int unsigned                    emit_row;
    bit                             pixels_complete;
    logic [b3blur_pkg::LW_BITS-1:0] width_reg;
    logic [b3blur_pkg::FH_BITS-1:0] height_reg;

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s, got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > b3blur_pkg::MAX_HEIGHT) h = b3blur_pkg::MAX_HEIGHT;
        return h;
    endfunction

    // new slice: counters and window cleared, line stores kept
    task automatic restart_slice();
        push_col = 0;
        push_row = 0;
        emit_col = 0;
        emit_row = 0;
        pixels_complete = 1'b0;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                win[k][j] = '0;
    endtask

    // one accepted input beat through line stores, window and border clamps
    task automatic advance_blur(input logic op, input logic signed [SB-1:0] value);
        int unsigned          w;
        int unsigned          h;
        int unsigned          c;
        bit                   pushes;
        bit                   due;
        bit                   last;
        logic signed [SB-1:0] px;
        logic signed [SB-1:0] t1;
        logic signed [SB-1:0] t2;
        int                   r;
        int                   l;
        int                   d;
        int                   u;
        int                   sum;
        blur_beat_t           beat;
        w = eff_width();
        h = eff_height();
        pushes = 1'b0;
        px = '0;
        // samples after the last pixel and flushes before it are dropped
        if (op == b3blur_pkg::OP_PIXEL)
        begin
            if (!pixels_complete)
            begin
                pushes = 1'b1;
                px = value;
                if (push_row == h - 1 && push_col == w - 1)
                    pixels_complete = 1'b1;
            end
        end
        else if (pixels_complete)
        begin
            pushes = 1'b1;
        end
        if (pushes)
        begin
            pushed_beats++;
            due = (push_row >= 2) || (push_row == 1 && push_col >= 1);
            c = push_col;
            t1 = row_above[c];
            t2 = row_above2[c];
            row_above2[c] = t1;
            row_above[c] = px;
            for (int k = 2; k > 0; k--)
                for (int j = 0; j < 3; j++)
                    win[k][j] = win[k-1][j];
            win[0][0] = px;
            win[0][1] = t1;
            win[0][2] = t2;
            push_col++;
            if (push_col >= w)
            begin
                push_col = 0;
                push_row++;
            end
            if (due)
            begin
                // clamp neighbour taps onto the centre at the slice border
                r = (emit_col == w - 1) ? 1 : 0;
                l = (emit_col == 0) ? 1 : 2;
                d = (emit_row == h - 1) ? 1 : 0;
                u = (emit_row == 0) ? 1 : 2;
                sum = 4 * win[1][1]
                    + 2 * (win[r][1] + win[l][1] + win[1][d] + win[1][u])
                    + win[l][u] + win[l][d] + win[r][u] + win[r][d];
                last = (emit_row == h - 1) && (emit_col == w - 1);
                beat.blurred = sum[OB-1:0];
                beat.frame_last = last;
                owed_beats.push_back(beat);
                if (last)
                begin
                    restart_slice();
                end
                else
                begin
                    emit_col++;
                    if (emit_col >= w)
                    begin
                        emit_col = 0;
                        emit_row++;
                    end
                end
            end
        end
    endtask

    // result side: random stall before each beat, compare on every accepted beat
    initial
    begin : sink_side
        int stall;
        pix_out.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, out_gap_max);
            if (stall > 0)
            begin
                pix_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge clk); while (!pix_out.valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_beats
        blur_beat_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (owed_beats.size() == 0)
            begin
                report_mismatch("blurred beat with none owed", $signed(pix_out.blurred), 0);
            end
            else
            begin
                want = owed_beats.pop_front();
                if (pix_out.blurred !== want.blurred)
                    report_mismatch("blurred", $signed(pix_out.blurred), $signed(want.blurred));
                if (pix_out.frame_last !== want.frame_last)
                    report_mismatch("frame_last", pix_out.frame_last, want.frame_last);
            end
        end
    end

    // one input beat with a random gap ahead of it, returns at a falling edge
    task automatic send_beat(input logic op, input logic signed [SB-1:0] value);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in.valid  <= 1'b1;
        pix_in.opcode <= op;
        pix_in.sample <= value;
        do @(posedge clk); while (!pix_in.ready);
        advance_blur(op, value);
        @(negedge clk);
    endtask

    // stream stopped, all owed beats in, pipeline settled
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (owed_beats.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx,
                              input logic [b3blur_pkg::APB_DATA_BITS-1:0] data,
                              output logic [b3blur_pkg::APB_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= b3blur_pkg::APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_setting(input logic idx);
        logic [b3blur_pkg::APB_DATA_BITS-1:0] got;
        logic [b3blur_pkg::APB_DATA_BITS-1:0] want;
        apb_access(1'b0, idx, '0, got);
        want = (idx == b3blur_pkg::REG_LINE_WIDTH) ?
               b3blur_pkg::APB_DATA_BITS'(width_reg) :
               b3blur_pkg::APB_DATA_BITS'(height_reg);
        if (got !== want)
            report_mismatch(idx == b3blur_pkg::REG_LINE_WIDTH ? "line_width readback" :
                            "frame_height readback", got, want);
    endtask

    task automatic write_setting(input logic idx,
                                 input logic [b3blur_pkg::APB_DATA_BITS-1:0] value);
        logic [b3blur_pkg::APB_DATA_BITS-1:0] unused;
        wait_idle();
        apb_access(1'b1, idx, value, unused);
        if (idx == b3blur_pkg::REG_LINE_WIDTH)
            width_reg = value[b3blur_pkg::LW_BITS-1:0];
        else
            height_reg = value[b3blur_pkg::FH_BITS-1:0];
        restart_slice();
        check_setting(idx);
    endtask

    function automatic logic signed [SB-1:0] pick_sample(input fill_t fill);
        logic [SB-1:0] v;
        case (fill)
            FILL_MAX: v = {1'b0, {(SB-1){1'b1}}};
            FILL_MIN: v = {1'b1, {(SB-1){1'b0}}};
            default:
            begin
                case ($urandom_range(0, 7))
                    0:       v = {1'b0, {(SB-1){1'b1}}};
                    1:       v = {1'b1, {(SB-1){1'b0}}};
                    2:       v = SB'($urandom_range(0, 32)) - SB'(16);
                    default: v = SB'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    // gaps on both sides for this stretch, sometimes none at all
    task automatic pick_idling();
        in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 11;
        out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
    endtask

    // pixels with stray flushes, then flushes with stray samples until the slice closes
    task automatic send_slice(input int unsigned npix, input fill_t fill, input int noise_pct);
        pick_idling();
        for (int unsigned i = 0; i < npix; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(b3blur_pkg::OP_FLUSH, SB'($urandom));
            send_beat(b3blur_pkg::OP_PIXEL, pick_sample(fill));
        end
        while (pixels_complete)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(b3blur_pkg::OP_PIXEL, pick_sample(FILL_RANDOM));
            else
                send_beat(b3blur_pkg::OP_FLUSH, SB'($urandom));
        end
    endtask

    // reset geometry, a flush with nothing pending, first pixels of a full size slice
    task automatic test_reset_defaults();
        check_setting(b3blur_pkg::REG_LINE_WIDTH);
        check_setting(b3blur_pkg::REG_FRAME_HEIGHT);
        send_beat(b3blur_pkg::OP_FLUSH, SB'($urandom));
        send_slice(16, FILL_RANDOM, 0);
    endtask

    // zero geometry acting as one pixel, then full scale positive and negative
    task automatic test_extremes();
        write_setting(b3blur_pkg::REG_LINE_WIDTH, 0);
        write_setting(b3blur_pkg::REG_FRAME_HEIGHT, 0);
        send_slice(1, FILL_MAX, 30);
        write_setting(b3blur_pkg::REG_LINE_WIDTH, 3);
        write_setting(b3blur_pkg::REG_FRAME_HEIGHT, 3);
        send_slice(9, FILL_MAX, 0);
        send_slice(9, FILL_MIN, 0);
    endtask

    // register write in the middle of a slice, then back to back slices
    task automatic test_restart_mid_slice();
        write_setting(b3blur_pkg::REG_LINE_WIDTH, 4);
        write_setting(b3blur_pkg::REG_FRAME_HEIGHT, 4);
        send_slice(7, FILL_RANDOM, 0);
        write_setting(b3blur_pkg::REG_FRAME_HEIGHT, 4);
        send_slice(16, FILL_RANDOM, 10);
        send_slice(16, FILL_RANDOM, 10);
    endtask

    // all ones on the bus: width saturates to the line store depth, start of a row
    task automatic test_wide_rows();
        write_setting(b3blur_pkg::REG_LINE_WIDTH, '1);
        write_setting(b3blur_pkg::REG_FRAME_HEIGHT, 2);
        send_slice(24, FILL_RANDOM, 2);
    endtask

    // one pixel column with the height saturated, top part of the slice
    task automatic test_tall_slice();
        write_setting(b3blur_pkg::REG_LINE_WIDTH, 1);
        write_setting(b3blur_pkg::REG_FRAME_HEIGHT, 8191);
        send_slice(24, FILL_RANDOM, 2);
    endtask

    // small random geometries, partial slices and noise
    task automatic test_random_slices();
        int unsigned                          start;
        int unsigned                          npix;
        int                                   pick;
        logic [b3blur_pkg::APB_DATA_BITS-1:0] value;
        start = pushed_beats;
        while (pushed_beats - start < RANDOM_PUSHES)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 2 || pick >= 4)
            begin
                case ($urandom_range(0, 9))
                    0:       value = 0;
                    1:       value = $urandom_range(16, 40);
                    default: value = $urandom_range(1, 9);
                endcase
                write_setting(b3blur_pkg::REG_LINE_WIDTH, ($urandom & ~32'h7FF) | value);
            end
            if (pick >= 3)
            begin
                value = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                write_setting(b3blur_pkg::REG_FRAME_HEIGHT, ($urandom & ~32'h1FFF) | value);
            end
            npix = eff_width() * eff_height();
            if ($urandom_range(0, 7) == 0)
                npix = $urandom_range(1, npix);
            send_slice(npix, FILL_RANDOM, ($urandom_range(0, 1) == 0) ? 0 : 15);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pix_in.valid  = 1'b0;
        pix_in.opcode = b3blur_pkg::OP_PIXEL;
        pix_in.sample = '0;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        width_reg  = b3blur_pkg::LW_RESET;
        height_reg = b3blur_pkg::FH_RESET;
        restart_slice();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_extremes();
        test_restart_mid_slice();
        test_wide_rows();
        test_tall_slice();
        test_random_slices();

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
